@@ sv/cobs_stream_decoder_macros.svh @@
// Assertion macros used by the checker file of the stream decoder.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef COBS_STREAM_DECODER_MACROS_SVH
`define COBS_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define COBSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cobs decoder check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define COBSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cobs decoder check failed");

`endif

@@ sv/cobsd_pkg.sv @@
// Types and constants of the COBS stream decoder.
// Depends on nothing; used by the step, result register, top level and checker files.
package cobsd_pkg;

    localparam int unsigned LEN_W = 16;
    localparam logic [7:0] FULL_GROUP_CODE = 8'd255;

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_ZERO_MISSING    = 2'd1,
        ST_TOO_SHORT       = 2'd2,
        ST_UNEXPECTED_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       out_byte;
        logic             done_res;
        status_t          status;
        logic [LEN_W-1:0] out_length;
    } res_item_t;

endpackage

@@ sv/cobsd_if.sv @@
// Valid/ready channel interfaces for encoded input words and decoded results.
// Depends on nothing.
interface cobsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface cobsd_res_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] out_length;

    modport source (output valid, output byte_valid, output out_byte, output done_res,
                    output status, output out_length, input ready);
    modport sink (input valid, input byte_valid, input out_byte, input done_res,
                  input status, input out_length, output ready);
endinterface

@@ sv/cobsd_step.sv @@
// Decoder state and the per-word step logic of the COBS stream decoder.
// Depends on cobsd_pkg.
module cobsd_step #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  cobsd_pkg::in_item_t  item,
    output cobsd_pkg::res_item_t res
);
    import cobsd_pkg::*;

    logic                   in_group_reg, in_group_next;
    logic [7:0]             group_left_reg, group_left_next;
    logic                   short_group_reg, short_group_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    status_t                error_reg, error_next;

    logic                   emit;
    logic [7:0]             emit_byte;
    logic [LENGTH_BITS-1:0] count_upd;
    status_t                status_w;
    logic [LEN_W-1:0]       length_w;

    always_comb
    begin
        in_group_next    = in_group_reg;
        group_left_next  = group_left_reg;
        short_group_next = short_group_reg;
        error_next       = error_reg;
        emit             = 1'b0;
        emit_byte        = 8'd0;

        if (error_reg == ST_OK)
        begin
            if (!in_group_reg)
            begin
                if (item.in_byte == 8'd0)
                begin
                    error_next = ST_UNEXPECTED_ZERO;
                end
                else
                begin
                    in_group_next    = 1'b1;
                    group_left_next  = item.in_byte - 8'd1;
                    short_group_next = (item.in_byte != FULL_GROUP_CODE);
                end
            end
            else if (group_left_reg != 8'd0)
            begin
                if (item.in_byte == 8'd0)
                begin
                    error_next = ST_UNEXPECTED_ZERO;
                end
                else
                begin
                    emit            = 1'b1;
                    emit_byte       = item.in_byte;
                    group_left_next = group_left_reg - 8'd1;
                end
            end
            else if (item.in_byte == 8'd0)
            begin
                // Frame delimiter at a group boundary.
                in_group_next    = 1'b0;
                short_group_next = 1'b0;
            end
            else
            begin
                // A short group implies a zero before the next group.
                emit             = short_group_reg;
                in_group_next    = 1'b1;
                group_left_next  = item.in_byte - 8'd1;
                short_group_next = (item.in_byte != FULL_GROUP_CODE);
            end
        end

        count_upd = (emit && !(&count_reg)) ? count_reg + 1'b1 : count_reg;

        status_w = error_next;
        if (item.is_last && error_next == ST_OK && in_group_next)
        begin
            if (group_left_next != 8'd0)
            begin
                status_w = ST_TOO_SHORT;
            end
            else if (short_group_next)
            begin
                status_w = ST_ZERO_MISSING;
            end
            else
            begin
                status_w = ST_OK;
            end
        end

        count_next = count_upd;
        if (item.is_last)
        begin
            // The last word of a buffer returns everything to reset.
            in_group_next    = 1'b0;
            group_left_next  = 8'd0;
            short_group_next = 1'b0;
            error_next       = ST_OK;
            count_next       = '0;
        end
    end

    generate
        if (LENGTH_BITS > LEN_W)
        begin : g_clamp
            assign length_w = (|count_upd[LENGTH_BITS-1:LEN_W]) ? '1 : count_upd[LEN_W-1:0];
        end
        else
        begin : g_extend
            assign length_w = LEN_W'(count_upd);
        end
    endgenerate

    always_comb
    begin
        res.byte_valid = emit;
        res.out_byte   = emit_byte;
        res.done_res   = item.is_last;
        res.status     = status_w;
        res.out_length = length_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_group_reg    <= 1'b0;
            group_left_reg  <= 8'd0;
            short_group_reg <= 1'b0;
            count_reg       <= '0;
            error_reg       <= ST_OK;
        end
        else if (fire)
        begin
            in_group_reg    <= in_group_next;
            group_left_reg  <= group_left_next;
            short_group_reg <= short_group_next;
            count_reg       <= count_next;
            error_reg       <= error_next;
        end
    end

endmodule

@@ sv/cobsd_out_reg.sv @@
// Result register of the COBS stream decoder: holds one result word for the sink.
// Depends on cobsd_pkg.
module cobsd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 take,
    input  cobsd_pkg::res_item_t res,
    output logic                 valid,
    output cobsd_pkg::res_item_t res_q
);
    import cobsd_pkg::*;

    logic      valid_reg, valid_next;
    res_item_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign valid = valid_reg;
    assign res_q = data_reg;

endmodule

@@ sv/cobs_stream_decoder.sv @@
// Top level of the byte-serial COBS stream decoder.
// Depends on cobsd_pkg, cobsd_if, cobsd_step and cobsd_out_reg.
//
// Usage: encoded words arrive on the enc channel (in_byte, is_last), one word per
// valid/ready handshake; is_last flags the final word of a buffer. For every
// accepted word exactly one result word leaves on the dec channel: byte_valid
// and out_byte carry a decoded byte or an implied zero, done_res marks the
// result of the final word, status carries the buffer status on that result
// (and the sticky error so far on others), and out_length is the running count
// of emitted bytes, clamped to 16 bits.
// Each word passes the input register, then the result register.
// Throughput is one word per cycle while dec.ready stays high; the decoder state
// update is small byte-wide logic.
// Reset clears the valid flags of both registers and all decoder state, so the first word after
// reset opens a new buffer. When the sink stalls, the result register holds its
// word, the input register holds the next one, and enc.ready drops only once
// both are full; nothing is lost or repeated.
module cobs_stream_decoder #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input logic         clk,
    input logic         rst_n,
    cobsd_byte_if.sink  enc,
    cobsd_res_if.source dec
);
    import cobsd_pkg::*;

    // Input register.
    logic     in_vld_reg, in_vld_next;
    in_item_t in_item_reg;

    logic      advance;
    logic      accept;
    res_item_t step_res;
    res_item_t out_res;
    logic      out_vld;

    // The input word moves on when the result register is empty or being emptied.
    assign advance    = in_vld_reg && (!out_vld || dec.ready);
    assign enc.ready  = !in_vld_reg || advance;
    assign accept     = enc.valid && enc.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.in_byte <= enc.in_byte;
            in_item_reg.is_last <= enc.is_last;
        end
    end

    // Decoder state and step logic; the state advances with each word.
    cobsd_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .res   (step_res)
    );

    // Result register facing the sink.
    cobsd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .take  (dec.ready),
        .res   (step_res),
        .valid (out_vld),
        .res_q (out_res)
    );

    assign dec.valid      = out_vld;
    assign dec.byte_valid = out_res.byte_valid;
    assign dec.out_byte   = out_res.out_byte;
    assign dec.done_res   = out_res.done_res;
    assign dec.status     = out_res.status;
    assign dec.out_length = out_res.out_length;

endmodule

@@ sv/cobsd_checker.sv @@
// Port-level checks of the COBS stream decoder and the bind that attaches them.
// Depends on cobsd_pkg and cobs_stream_decoder_macros.svh.
`include "cobs_stream_decoder_macros.svh"

module cobsd_props (
    input logic        clk,
    input logic        rst_n,
    input logic        enc_ready,
    input logic        dec_valid,
    input logic        dec_ready,
    input logic        byte_valid,
    input logic [7:0]  out_byte,
    input logic        done_res,
    input logic [1:0]  status,
    input logic [15:0] out_length
);
    import cobsd_pkg::*;

    // All payload bits of the result word in one vector.
    logic [27:0] res_word;

    assign res_word = {byte_valid, out_byte, done_res, status, out_length};

    // A stalled result word must hold still.
    `COBSD_ASSERT_NEXT(a_hold, dec_valid && !dec_ready, dec_valid && $stable(res_word))

    // A result with no decoded byte carries a zero byte.
    `COBSD_ASSERT_NOW(a_zero_byte, dec_valid && !byte_valid, out_byte == 8'd0)

    // Once a zero has broken the stream, nothing more is emitted.
    `COBSD_ASSERT_NOW(a_err_silent, dec_valid && status == ST_UNEXPECTED_ZERO, !byte_valid)

    // The source is only held off while both internal registers are full.
    `COBSD_ASSERT_NOW(a_ready, !enc_ready, dec_valid && !dec_ready)

endmodule

bind cobs_stream_decoder cobsd_props u_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .enc_ready  (enc.ready),
    .dec_valid  (dec.valid),
    .dec_ready  (dec.ready),
    .byte_valid (dec.byte_valid),
    .out_byte   (dec.out_byte),
    .done_res   (dec.done_res),
    .status     (dec.status),
    .out_length (dec.out_length)
);
